[rtl/core/tepq_pkg.sv]
// ----------------------------------------------------------------------------
// tepq_pkg
// Shared types and constants of the trace event packet queue.
// ----------------------------------------------------------------------------
package tepq_pkg;

    localparam int RING_DEPTH = 256;
    localparam int PTR_W      = $clog2(RING_DEPTH);
    localparam int WORD_CNT   = 8;
    localparam int WIDX_W     = $clog2(WORD_CNT);

    localparam logic [31:0] PKT_MAGIC     = 32'h4E53_5231;
    localparam logic [31:0] LOW_ADDR_MASK = 32'h0000_FFFF;
    localparam int          KIND_SHIFT    = 24;
    localparam int          REG_SHIFT     = 16;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    typedef enum logic {
        OP_RECORD = 1'b0,
        OP_SEND   = 1'b1
    } t_opcode;

    // Packet word positions
    typedef enum logic [WIDX_W-1:0] {
        W_MAGIC   = 3'd0,
        W_SEQ     = 3'd1,
        W_TAG     = 3'd2,
        W_ADDR    = 3'd3,
        W_DATA    = 3'd4,
        W_PC      = 3'd5,
        W_DROPS   = 3'd6,
        W_ZERO    = 3'd7
    } t_word_idx;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } t_state;

    // One stored event
    typedef struct packed {
        logic [7:0]  kind;
        logic [7:0]  reg_num;
        logic [31:0] address;
        logic [31:0] data;
        logic [31:0] pc;
        logic [31:0] sequence_num;
    } t_entry;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

endpackage

[rtl/core/trace_event_packet_queue_core.sv]
// ----------------------------------------------------------------------------
// trace_event_packet_queue_core
// Trace event ring queue that sends each popped event as an eight-word packet.
// ----------------------------------------------------------------------------
// A record item leaves busy low, so records can arrive on every cycle while
// no send is busy. A send with an empty ring gives nothing. A send with an
// event queued raises busy until its last word has left: the entry is read
// from the ring memory at the accepting edge and the packet words then leave
// one per cycle from that registered read, word 0 in the cycle right after
// acceptance. The receiver cannot stall: each word is valid for exactly one
// cycle under o_strobe, with o_last_word on the eighth. The ring holds
// RING_DEPTH-1 events; records into a full ring are dropped and counted.
module trace_event_packet_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [7:0]  i_event_kind,
    input  logic [7:0]  i_reg_number,
    input  logic [31:0] i_address,
    input  logic [31:0] i_data_value,
    input  logic [31:0] i_program_counter,
    output logic        o_strobe,
    output logic [31:0] o_packet_word,
    output logic        o_last_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data
);
    import tepq_pkg::*;

    t_state             r_state, n_state;
    logic [WIDX_W-1:0]  r_widx, n_widx;
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [31:0]        r_drops, n_drops;
    logic [31:0]        r_seq, n_seq;
    logic               r_enable;

    logic               accept;
    logic               is_record;
    logic               is_send;
    logic               full;
    logic               empty;
    logic               ram_we;
    logic               ram_re;
    t_entry             wr_entry;
    t_entry             rd_entry;

    assign o_cfg_ready = 1'b1;
    assign busy        = (r_state == ST_SEND);
    assign accept      = start && !busy;
    assign is_record   = accept && (t_opcode'(i_opcode) == OP_RECORD) && r_enable;
    assign is_send     = accept && (t_opcode'(i_opcode) == OP_SEND);
    assign full        = (next_slot(r_wptr) == r_rptr);
    assign empty       = (r_wptr == r_rptr);
    assign ram_we      = is_record && !full;
    assign ram_re      = is_send && !empty;

    assign wr_entry = '{
        kind:         i_event_kind,
        reg_num:      i_reg_number,
        address:      i_address,
        data:         i_data_value,
        pc:           i_program_counter,
        sequence_num: n_seq
    };

    tepq_ring_ram u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wptr),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (r_rptr),
        .o_rdata (rd_entry)
    );

    always_comb begin
        n_state = r_state;
        n_widx  = r_widx;
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_drops = r_drops;
        n_seq   = r_seq;
        if (is_record) begin
            n_seq = r_seq + 32'd1;
            if (full) begin
                n_drops = r_drops + 32'd1;
            end else begin
                n_wptr = next_slot(r_wptr);
            end
        end
        case (r_state)
            ST_IDLE: begin
                if (ram_re) begin
                    n_state = ST_SEND;
                    n_widx  = '0;
                    n_rptr  = next_slot(r_rptr);
                end
            end
            ST_SEND: begin
                n_widx = r_widx + WIDX_W'(1);
                if (r_widx == WIDX_W'(WORD_CNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_widx   <= '0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_drops  <= '0;
            r_seq    <= '0;
            r_enable <= 1'b0;
        end else begin
            r_state <= n_state;
            r_widx  <= n_widx;
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_drops <= n_drops;
            r_seq   <= n_seq;
            if (i_cfg_valid && o_cfg_ready) begin
                r_enable <= i_cfg_data;
            end
        end
    end

    // Drop count cannot move while busy, so word 6 reads the live counter.
    always_comb begin
        case (t_word_idx'(r_widx))
            W_MAGIC: o_packet_word = PKT_MAGIC;
            W_SEQ:   o_packet_word = rd_entry.sequence_num;
            W_TAG:   o_packet_word = (32'(rd_entry.kind) << KIND_SHIFT)
                                   | (32'(rd_entry.reg_num) << REG_SHIFT)
                                   | (rd_entry.address & LOW_ADDR_MASK);
            W_ADDR:  o_packet_word = rd_entry.address;
            W_DATA:  o_packet_word = rd_entry.data;
            W_PC:    o_packet_word = rd_entry.pc;
            W_DROPS: o_packet_word = r_drops;
            W_ZERO:  o_packet_word = '0;
            default: o_packet_word = '0;
        endcase
    end

    assign o_strobe    = (r_state == ST_SEND);
    assign o_last_word = o_strobe && (r_widx == WIDX_W'(WORD_CNT - 1));

endmodule

[rtl/core/tepq_ring_ram.sv]
// ----------------------------------------------------------------------------
// tepq_ring_ram
// Event ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tepq_ring_ram (
    input  logic                   i_clk,
    input  logic                   i_we,
    input  logic [tepq_pkg::PTR_W-1:0] i_waddr,
    input  tepq_pkg::t_entry       i_wdata,
    input  logic                   i_re,
    input  logic [tepq_pkg::PTR_W-1:0] i_raddr,
    output tepq_pkg::t_entry       o_rdata
);
    import tepq_pkg::*;

    t_entry r_mem [RING_DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/tepq_checker.sv]
// ----------------------------------------------------------------------------
// tepq_checker
// Port-level checks on packet framing of the trace event packet queue.
// ----------------------------------------------------------------------------
module tepq_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        busy,
    input logic        o_strobe,
    input logic [31:0] o_packet_word,
    input logic        o_last_word
);
    import tepq_pkg::*;

    // Words only come out while the queue refuses new items
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("packet word emitted while not busy");

    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_word |-> o_strobe)
        else $error("last word flag without strobe");

    // A packet runs without gaps until its last word
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_word) |=> o_strobe)
        else $error("gap inside packet");

    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_word) |=> !o_strobe)
        else $error("word after last word");

    a_magic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !$past(o_strobe)) |-> (o_packet_word == PKT_MAGIC))
        else $error("packet does not open with magic");

endmodule

bind trace_event_packet_queue_core tepq_checker u_tepq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_packet_word (o_packet_word),
    .o_last_word   (o_last_word)
);

[tb/sv/tb_event_queue_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_queue_pkg
// Scoreboard for the trace event packet queue: shadows the ring, the pointers
// and the counters, and checks every packet word against the predicted stream.
// ----------------------------------------------------------------------------
package tb_event_queue_pkg;
    import tepq_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic        last;
    } t_pkt_word;

    class event_queue_shadow;
        t_entry           ring [RING_DEPTH];
        logic [PTR_W-1:0] wr_ptr;
        logic [PTR_W-1:0] rd_ptr;
        logic [31:0]      drop_cnt;
        logic [31:0]      seq_cnt;
        logic             enabled;
        t_pkt_word        due_words [$];
        int unsigned      faults;

        function new();
            wr_ptr   = '0;
            rd_ptr   = '0;
            drop_cnt = '0;
            seq_cnt  = '0;
            enabled  = 1'b0;
            faults   = 0;
        endfunction

        function void set_enable(logic v);
            enabled = v;
        endfunction

        // Predict the packet words that one accepted item causes.
        function void take_item(t_opcode op, logic [7:0] kind, logic [7:0] reg_num,
                                logic [31:0] addr, logic [31:0] data, logic [31:0] pc);
            logic [PTR_W-1:0] nxt;
            t_entry           e;
            logic [31:0]      tag_word;
            if (op == OP_RECORD) begin
                if (!enabled) return;
                seq_cnt = seq_cnt + 32'd1;
                nxt = PTR_W'((int'(wr_ptr) + 1) % RING_DEPTH);
                // one slot stays free: a full ring drops the item
                if (nxt == rd_ptr) begin
                    drop_cnt = drop_cnt + 32'd1;
                    return;
                end
                ring[wr_ptr] = '{kind: kind, reg_num: reg_num, address: addr,
                                 data: data, pc: pc, sequence_num: seq_cnt};
                wr_ptr = nxt;
            end else if (rd_ptr != wr_ptr) begin
                e = ring[rd_ptr];
                tag_word = (32'(e.kind) << KIND_SHIFT) | (32'(e.reg_num) << REG_SHIFT) |
                           (e.address & LOW_ADDR_MASK);
                due_words.push_back('{PKT_MAGIC, 1'b0});
                due_words.push_back('{e.sequence_num, 1'b0});
                due_words.push_back('{tag_word, 1'b0});
                due_words.push_back('{e.address, 1'b0});
                due_words.push_back('{e.data, 1'b0});
                due_words.push_back('{e.pc, 1'b0});
                due_words.push_back('{drop_cnt, 1'b0});
                due_words.push_back('{32'd0, 1'b1});
                rd_ptr = PTR_W'((int'(rd_ptr) + 1) % RING_DEPTH);
            end
        endfunction

        function void fault(string msg);
            faults++;
            if (faults <= 10) $display("mismatch: %s", msg);
        endfunction

        function void check_word(logic [31:0] word, logic last);
            t_pkt_word want;
            if (due_words.size() == 0) begin
                fault($sformatf("unexpected word %h last %b", word, last));
                return;
            end
            want = due_words.pop_front();
            if (want.word !== word || want.last !== last)
                fault($sformatf("expected %h last %b, got %h last %b",
                                want.word, want.last, word, last));
        endfunction
    endclass

endpackage

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives record and send items in random bursts, toggles the enable register
// between phases, overruns the ring, and checks each packet word in order.
// ----------------------------------------------------------------------------
module tb_top;
    import tepq_pkg::*;
    import tb_event_queue_pkg::*;

    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 12;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_opcode;
    logic [7:0]  i_event_kind;
    logic [7:0]  i_reg_number;
    logic [31:0] i_address;
    logic [31:0] i_data_value;
    logic [31:0] i_program_counter;
    logic        o_strobe;
    logic [31:0] o_packet_word;
    logic        o_last_word;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_data;

    event_queue_shadow shadow;
    int idle_cycles = 0;
    int burst_left;

    trace_event_packet_queue_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_opcode          (i_opcode),
        .i_event_kind      (i_event_kind),
        .i_reg_number      (i_reg_number),
        .i_address         (i_address),
        .i_data_value      (i_data_value),
        .i_program_counter (i_program_counter),
        .o_strobe          (o_strobe),
        .o_packet_word     (o_packet_word),
        .o_last_word       (o_last_word),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Sample handshakes and results at the rising edge; inputs move at the falling edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            idle_cycles++;
            if (start && !busy) begin
                shadow.take_item(t_opcode'(i_opcode), i_event_kind, i_reg_number,
                                 i_address, i_data_value, i_program_counter);
                idle_cycles = 0;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                shadow.set_enable(i_cfg_data);
                idle_cycles = 0;
            end
            if (o_strobe) begin
                shadow.check_word(o_packet_word, o_last_word);
                idle_cycles = 0;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic issue(t_opcode op, logic [7:0] kind, logic [7:0] reg_num,
                         logic [31:0] addr, logic [31:0] data, logic [31:0] pc);
        logic took;
        i_opcode          = op;
        i_event_kind      = kind;
        i_reg_number      = reg_num;
        i_address         = addr;
        i_data_value      = data;
        i_program_counter = pc;
        start             = 1'b1;
        do begin
            @(posedge i_clk);
            took = !busy;
            @(negedge i_clk);
        end while (!took);
        // hold start across a burst, drop it for a random gap at the end
        burst_left--;
        if (burst_left <= 0) begin
            start = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
    endtask

    task automatic issue_random(int unsigned send_pct);
        t_opcode op;
        op = ($urandom_range(0, 99) < send_pct) ? OP_SEND : OP_RECORD;
        issue(op, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
    endtask

    // Wait for every expected word, then let a trailing empty send finish.
    task automatic settle();
        start = 1'b0;
        while (shadow.due_words.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_enable(logic v);
        logic took;
        settle();
        i_cfg_data  = v;
        i_cfg_valid = 1'b1;
        do begin
            @(posedge i_clk);
            took = o_cfg_ready;
            @(negedge i_clk);
        end while (!took);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        shadow            = new();
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_opcode          = OP_RECORD;
        i_event_kind      = '0;
        i_reg_number      = '0;
        i_address         = '0;
        i_data_value      = '0;
        i_program_counter = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_data        = 1'b0;
        burst_left        = $urandom_range(1, 30);
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // enable is low out of reset: records are ignored, sends find nothing
        issue(OP_SEND, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0);
        issue(OP_RECORD, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_SEND, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        write_enable(1'b1);
        issue(OP_RECORD, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0);
        issue(OP_RECORD, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(OP_RECORD, 8'hA5, 8'h5A, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0F0F_F0F0);
        repeat (3) issue(OP_SEND, 8'($urandom), 8'($urandom), $urandom, $urandom, $urandom);
        issue(OP_SEND, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0);
        issue(OP_RECORD, 8'h01, 8'h80, 32'h8000_0001, 32'h0000_0001, 32'h8000_0000);
        issue(OP_RECORD, 8'h80, 8'h01, 32'h0001_8000, 32'h8000_0000, 32'h0000_0001);

        // sends still drain the ring while records are switched off
        write_enable(1'b0);
        issue(OP_RECORD, 8'h12, 8'h34, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0BAD_F00D);
        repeat (3) issue(OP_SEND, 8'h00, 8'h00, 32'h0, 32'h0, 32'h0);

        write_enable(1'b1);
        repeat (130) issue_random(45);

        write_enable(1'b0);
        repeat (40) issue_random(50);

        // overrun the ring so records get dropped and counted
        write_enable(1'b1);
        repeat (270) issue_random(0);
        repeat (60) issue_random(60);

        settle();
        shadow.faults += shadow.due_words.size();
        if (shadow.faults == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
